// ----- hdl/ctrs_pkg.sv -----
// Shared types and constants of the color temperature ramp scaler.
package ctrs_pkg;

  // Gain format: unsigned Q16, 0 .. 1.0
  localparam int unsigned GAIN_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_ZERO = 17'd0;

  // Channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Register index (byte address bit 2)
  localparam logic CFG_IDX_KELVIN = 1'b0;
  localparam logic [15:0] KELVIN_RESET = 16'd6500;
  localparam logic [15:0] KELVIN_MIN   = 16'd1000;
  localparam logic [15:0] KELVIN_MAX   = 16'd40000;
  localparam logic [15:0] KELVIN_KNEE  = 16'd6600;
  localparam logic [15:0] KELVIN_BLUE0 = 16'd1900;

  // ln 2 in Q32; curve fit constants scaled by 1e8
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [34:0] A_GRN   = 35'd9947080259;
  localparam logic [34:0] B_GRN   = 35'd16111956817;
  localparam logic [34:0] A_BLU   = 35'd13851773122;
  localparam logic [34:0] B_BLU   = 35'd30504479273;
  localparam logic [34:0] C_RED   = 35'd32969872745;
  localparam logic [34:0] C_GRN   = 35'd28812216953;
  localparam logic [23:0] EX_RED  = 24'd13320476;
  localparam logic [23:0] EX_GRN  = 24'd7551485;

  // Fixed divisors: 1e8, and 255e8 taken as a shift by 8 then 99609375
  localparam logic [26:0] E8     = 27'd100000000;
  localparam logic [26:0] DEN_LO = 27'd99609375;
  // Reciprocals floor(2^58 / d)
  localparam logic [31:0] E8_RCP     = 32'((64'd1 << 58) / 64'd100000000);
  localparam logic [31:0] DEN_LO_RCP = 32'((64'd1 << 58) / 64'd99609375);

  // Status from the gain calculator to the datapath
  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] gain_r;
    logic [GAIN_W-1:0] gain_g;
    logic [GAIN_W-1:0] gain_b;
  } ctrs_calc_t;

endpackage

// ----- hdl/ctrs_gain_calc.sv -----
// Sequencer that derives the three channel gains from the white point.
module ctrs_gain_calc (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        kelvin,
  output ctrs_pkg::ctrs_calc_t calc
);
  import ctrs_pkg::*;

  typedef enum logic [28:0] {
    S_IDLE     = 29'h0000001,
    S_START    = 29'h0000002,
    S_CH       = 29'h0000004,
    S_LN_INIT  = 29'h0000008,
    S_LN_Z2    = 29'h0000010,
    S_LN_SQ    = 29'h0000020,
    S_LN_TERM  = 29'h0000040,
    S_LN_TDIV  = 29'h0000080,
    S_LN_ACC   = 29'h0000100,
    S_LN_DONE  = 29'h0000200,
    S_PMUL     = 29'h0000400,
    S_POW_DIV  = 29'h0000800,
    S_EXP_INIT = 29'h0001000,
    S_EXP_MUL  = 29'h0002000,
    S_EXP_DIV  = 29'h0004000,
    S_EXP_ACC  = 29'h0008000,
    S_EXP_FIN  = 29'h0010000,
    S_MLO      = 29'h0020000,
    S_MHI      = 29'h0040000,
    S_MADD     = 29'h0080000,
    S_GAIN     = 29'h0100000,
    S_GAIN_FIN = 29'h0200000,
    S_NEXT     = 29'h0400000,
    S_DIV      = 29'h0800000,
    S_RCP_MUL  = 29'h1000000,
    S_RCP_Q    = 29'h2000000,
    S_RCP_BACK = 29'h4000000,
    S_RCP_REM  = 29'h8000000,
    S_RCP_FIX  = 29'h10000000
  } state_t;

  state_t state, div_ret;

  logic [15:0]        kel;
  logic [1:0]         gch;
  logic [15:0]        n;
  logic               is100;
  logic               mode_pow;
  logic [4:0]         e_r;
  logic [39:0]        ln100;
  logic [31:0]        lval;
  logic [31:0]        z2;
  logic [31:0]        term;
  logic [33:0]        sum;
  logic [33:0]        esum;
  logic [31:0]        xq;
  logic [4:0]         kk;
  logic [63:0]        mul_q;
  logic [63:0]        acc;
  logic [63:0]        num;
  logic [34:0]        div_rem;
  logic [63:0]        div_quo;
  logic [34:0]        div_dvs;
  logic [5:0]         div_cnt;
  logic [57:0]        cx;
  logic [31:0]        cq;
  logic [57:0]        cr;
  logic               cdiv_gain;
  logic [GAIN_W-1:0]  gain [3];

  // Leading one of n
  logic [4:0]  e_c;
  logic [16:0] p_c;
  always_comb begin
    e_c = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (n[i]) e_c = 5'(i);
    end
    p_c = 17'd1 << e_c;
  end

  // ln(n) in Q32 and its distance above ln(100), also in Q32 (taken to Q24 by a shift of 8)
  logic [39:0] ln_u;
  logic [39:0] ln_d;
  assign ln_u = 40'(e_r) * 40'(LN2_Q32) + {5'd0, sum, 1'b0};
  assign ln_d = ln_u - ln100;

  // Curve constants for the channel in work
  logic [34:0] cst;
  logic [34:0] bq;
  logic [23:0] exq;
  always_comb begin
    case (gch)
      CH_RED:   cst = C_RED;
      CH_GREEN: cst = mode_pow ? C_GRN : A_GRN;
      CH_BLUE:  cst = A_BLU;
      default:  cst = 35'd0;
    endcase
    bq  = (gch == CH_GREEN) ? B_GRN : B_BLU;
    exq = (gch == CH_RED) ? EX_RED : EX_GRN;
  end

  // Fixed divisor and its reciprocal
  logic [26:0] cd;
  logic [31:0] cm;
  assign cd = cdiv_gain ? DEN_LO : E8;
  assign cm = cdiv_gain ? DEN_LO_RCP : E8_RCP;

  // Shared 32x32 multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    case (state)
      S_LN_Z2:    begin mul_a = div_quo[31:0];       mul_b = div_quo[31:0]; end
      S_LN_TERM:  begin mul_a = term;                mul_b = z2;            end
      S_EXP_MUL:  begin mul_a = term;                mul_b = xq;            end
      S_PMUL:     begin mul_a = {8'd0, exq};         mul_b = lval;          end
      S_MLO:      begin mul_a = cst[31:0];           mul_b = lval;          end
      S_MHI:      begin mul_a = {29'd0, cst[34:32]}; mul_b = lval;          end
      S_RCP_MUL:  begin mul_a = cx[57:26];           mul_b = cm;            end
      S_RCP_BACK: begin mul_a = cq;                  mul_b = {5'd0, cd};    end
      default:    begin mul_a = 32'd0;               mul_b = 32'd0;         end
    endcase
  end

  // Restoring divider step, one quotient bit per cycle
  logic [35:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {div_rem, div_quo[63]};
  assign rem_ge = rem_sh >= {1'b0, div_dvs};

  // Gain rounding to Q16
  logic [63:0] q16w;
  assign q16w = (div_quo + 64'd128) >> 8;

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    if (rst || start) begin
      state <= S_START;
    end else begin
      case (state)
        S_IDLE: begin
          state <= S_IDLE;
        end
        S_START: begin
          if (kelvin < KELVIN_MIN)      kel <= KELVIN_MIN;
          else if (kelvin > KELVIN_MAX) kel <= KELVIN_MAX;
          else                          kel <= kelvin;
          n     <= 16'd100;
          is100 <= 1'b1;
          gch   <= CH_RED;
          state <= S_LN_INIT;
        end
        S_CH: begin
          state <= S_LN_INIT;
          case (gch)
            CH_RED: begin
              if (kel <= KELVIN_KNEE) begin
                gain[gch] <= GAIN_ONE;
                state     <= S_NEXT;
              end else begin
                n        <= kel - 16'd6000;
                mode_pow <= 1'b1;
              end
            end
            CH_GREEN: begin
              if (kel <= KELVIN_KNEE) begin
                n        <= kel;
                mode_pow <= 1'b0;
              end else begin
                n        <= kel - 16'd6000;
                mode_pow <= 1'b1;
              end
            end
            default: begin
              if (kel >= KELVIN_KNEE) begin
                gain[gch] <= GAIN_ONE;
                state     <= S_NEXT;
              end else if (kel <= KELVIN_BLUE0) begin
                gain[gch] <= GAIN_ZERO;
                state     <= S_NEXT;
              end else begin
                n        <= kel - 16'd1000;
                mode_pow <= 1'b0;
              end
            end
          endcase
        end
        // z = (n - p) / (n + p)
        S_LN_INIT: begin
          e_r     <= e_c;
          div_rem <= 35'd0;
          div_quo <= {16'd0, 16'(17'(n) - p_c), 32'd0};
          div_dvs <= 35'(17'(n) + p_c);
          div_cnt <= 6'd0;
          div_ret <= S_LN_Z2;
          state   <= S_DIV;
        end
        S_LN_Z2: begin
          term  <= div_quo[31:0];
          sum   <= {2'd0, div_quo[31:0]};
          state <= S_LN_SQ;
        end
        S_LN_SQ: begin
          z2    <= mul_q[63:32];
          kk    <= 5'd3;
          state <= S_LN_TERM;
        end
        S_LN_TERM: begin
          state <= S_LN_TDIV;
        end
        S_LN_TDIV: begin
          term    <= mul_q[63:32];
          div_rem <= 35'd0;
          div_quo <= {32'd0, mul_q[63:32]};
          div_dvs <= 35'(kk);
          div_cnt <= 6'd0;
          div_ret <= S_LN_ACC;
          state   <= S_DIV;
        end
        S_LN_ACC: begin
          sum <= sum + div_quo[33:0];
          if (kk == 5'd31) begin
            state <= S_LN_DONE;
          end else begin
            kk    <= kk + 5'd2;
            state <= S_LN_TERM;
          end
        end
        S_LN_DONE: begin
          if (is100) begin
            ln100 <= ln_u;
            is100 <= 1'b0;
            state <= S_CH;
          end else begin
            lval  <= (ln_u > ln100) ? ln_d[39:8] : 32'd0;
            state <= mode_pow ? S_PMUL : S_MLO;
          end
        end
        S_PMUL: begin
          state <= S_POW_DIV;
        end
        // exponent magnitude: product / 1e8
        S_POW_DIV: begin
          cx        <= mul_q[57:0];
          cdiv_gain <= 1'b0;
          div_ret   <= S_EXP_INIT;
          state     <= S_RCP_MUL;
        end
        // first series term is x itself
        S_EXP_INIT: begin
          if (|div_quo[63:24]) begin
            xq   <= 32'hFFFF_FFFF;
            term <= 32'hFFFF_FFFF;
            esum <= 34'h1_0000_0000 - 34'h0_FFFF_FFFF;
          end else begin
            xq   <= {div_quo[23:0], 8'd0};
            term <= {div_quo[23:0], 8'd0};
            esum <= 34'h1_0000_0000 - {2'd0, div_quo[23:0], 8'd0};
          end
          kk    <= 5'd2;
          state <= S_EXP_MUL;
        end
        S_EXP_MUL: begin
          state <= S_EXP_DIV;
        end
        S_EXP_DIV: begin
          div_rem <= 35'd0;
          div_quo <= {32'd0, mul_q[63:32]};
          div_dvs <= 35'(kk);
          div_cnt <= 6'd0;
          div_ret <= S_EXP_ACC;
          state   <= S_DIV;
        end
        S_EXP_ACC: begin
          term <= div_quo[31:0];
          if (kk[0]) esum <= esum - {2'd0, div_quo[31:0]};
          else       esum <= esum + {2'd0, div_quo[31:0]};
          if (kk == 5'd20) begin
            state <= S_EXP_FIN;
          end else begin
            kk    <= kk + 5'd1;
            state <= S_EXP_MUL;
          end
        end
        S_EXP_FIN: begin
          lval  <= esum[33] ? 32'd0 : {7'd0, esum[32:8]};
          state <= S_MLO;
        end
        // 35x32 product in two passes
        S_MLO: begin
          state <= S_MHI;
        end
        S_MHI: begin
          acc   <= mul_q;
          state <= S_MADD;
        end
        S_MADD: begin
          num   <= acc + {mul_q[31:0], 32'd0}
                   - (mode_pow ? 64'd0 : {5'd0, bq, 24'd0});
          state <= S_GAIN;
        end
        // gain in Q24: (num >> 8) / 99609375
        S_GAIN: begin
          if (num[63] || num == 64'd0) begin
            gain[gch] <= GAIN_ZERO;
            state     <= S_NEXT;
          end else begin
            cx        <= {2'd0, num[63:8]};
            cdiv_gain <= 1'b1;
            div_ret   <= S_GAIN_FIN;
            state     <= S_RCP_MUL;
          end
        end
        S_GAIN_FIN: begin
          gain[gch] <= (q16w > 64'(GAIN_ONE)) ? GAIN_ONE : q16w[GAIN_W-1:0];
          state     <= S_NEXT;
        end
        S_NEXT: begin
          if (gch == CH_BLUE) begin
            state <= S_IDLE;
          end else begin
            gch   <= gch + 2'd1;
            state <= S_CH;
          end
        end
        S_DIV: begin
          div_rem <= rem_ge ? 35'(rem_sh - {1'b0, div_dvs}) : rem_sh[34:0];
          div_quo <= {div_quo[62:0], rem_ge};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) state <= div_ret;
        end
        // Fixed divisor: reciprocal estimate, low by at most two, then corrected
        S_RCP_MUL: begin
          state <= S_RCP_Q;
        end
        S_RCP_Q: begin
          cq    <= mul_q[63:32];
          state <= S_RCP_BACK;
        end
        S_RCP_BACK: begin
          state <= S_RCP_REM;
        end
        S_RCP_REM: begin
          cr    <= cx - mul_q[57:0];
          state <= S_RCP_FIX;
        end
        S_RCP_FIX: begin
          if (cr >= {31'd0, cd}) begin
            cr <= cr - {31'd0, cd};
            cq <= cq + 32'd1;
          end else begin
            div_quo <= {32'd0, cq};
            state   <= div_ret;
          end
        end
        default: begin
          state <= S_START;
        end
      endcase
    end
  end

  assign calc.busy   = (state != S_IDLE);
  assign calc.gain_r = gain[0];
  assign calc.gain_g = gain[1];
  assign calc.gain_b = gain[2];

endmodule

// ----- hdl/color_temperature_ramp_scaler_core.sv -----
// Top level of the color temperature ramp scaler: register port and scaling pipeline.
// Scales streamed gamma-ramp entries by per-channel gains derived from the white point in
// color_temp_kelvin (clamped to 1000..40000 K). The datapath takes one beat per cycle when
// not stalled and returns each result through registered stages (gain select, 16x17 multiply,
// round and saturate), with output backpressure stalling the stages in place. After reset and
// after every write to color_temp_kelvin the gains are recomputed by a sequencer built on one
// shared 32x32 multiplier, a bit-serial divider for the logarithm and series terms, and a
// reciprocal multiply with a short correction for the fixed divisions by 1e8 and 255e8;
// in_ready stays low for that time, longest with power-law red and green above 6600 K,
// shorter between 1900 and 6600 K, and shortest when blue needs no curve (at or below 1900 K,
// or exactly 6600 K). Channel code three passes base_value through unscaled.
module color_temperature_ramp_scaler_core (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  channel,
  input  logic [15:0] base_value,
  // output beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] scaled_value
);
  import ctrs_pkg::*;

  logic [15:0] kelvin;
  logic        cfg_wr;
  ctrs_calc_t  calc;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_KELVIN);
  assign prdata = (paddr[2] == CFG_IDX_KELVIN) ? {16'd0, kelvin} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kelvin <= KELVIN_RESET;
    end else if (cfg_wr) begin
      kelvin <= pwdata[15:0];
    end
  end

  ctrs_gain_calc u_calc (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_wr),
    .kelvin (kelvin),
    .calc   (calc)
  );

  // Stage enables
  logic v1, v2, en1, en2, en3, accept;
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1 && !calc.busy;
  assign accept   = in_valid && in_ready;

  // Gain select
  logic [GAIN_W-1:0] gain_sel;
  always_comb begin
    case (channel)
      CH_RED:   gain_sel = calc.gain_r;
      CH_GREEN: gain_sel = calc.gain_g;
      CH_BLUE:  gain_sel = calc.gain_b;
      default:  gain_sel = GAIN_ONE;
    endcase
  end

  logic [15:0]       base1;
  logic [GAIN_W-1:0] gain1;
  logic [32:0]       prod2;
  logic [32:0]       rnd;

  assign rnd = prod2 + 33'd32768;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= accept;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  // Pipeline data
  always_ff @(posedge clk) begin
    if (accept) begin
      base1 <= base_value;
      gain1 <= gain_sel;
    end
    if (en2 && v1) prod2 <= base1 * gain1;
    if (en3 && v2) scaled_value <= rnd[32] ? 16'hFFFF : rnd[31:16];
  end

  // Checks
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    accept |=> v1) else $error("accepted beat not in first stage");
  a_stage_moves : assert property (@(posedge clk) disable iff (rst)
    (v2 && en3) |=> out_valid) else $error("second stage beat lost");
  a_gain_range : assert property (@(posedge clk) disable iff (rst)
    !calc.busy |-> (calc.gain_r <= GAIN_ONE && calc.gain_g <= GAIN_ONE
                    && calc.gain_b <= GAIN_ONE)) else $error("gain above one");

endmodule

// ----- verif/testbench.sv -----
// Testbench of the color temperature ramp scaler: gain prediction, stimulus and checking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctrs_pkg::*;

  localparam longint unsigned LN2_Q32_V = 64'd2977044472;
  localparam longint unsigned DEN_Q24_V = 64'd25500000000;
  localparam int WATCHDOG_LIMIT = 40000;

  // Per-channel gain calculator, fixed point, mirrors the hardware arithmetic
  class ramp_scoreboard;
    bit [15:0] kelvin;
    bit [16:0] gains [4];
    bit [15:0] pending_scaled [$];
    int errors;

    function new();
      kelvin = KELVIN_RESET;
      errors = 0;
      update_gains();
    endfunction

    function longint ln_fixed(int unsigned n);
      int unsigned e;
      longint unsigned p, z, z2, term, sum;
      e = 0;
      if (n == 0) n = 1;
      while (e < 31 && (n >> (e + 1)) != 0) e++;
      p = 64'd1 << e;
      z = ((64'(n) - p) << 32) / (64'(n) + p);
      z2 = (z * z) >> 32;
      term = z;
      sum = z;
      for (int k = 3; k <= 31; k += 2) begin
        term = (term * z2) >> 32;
        sum += term / k;
      end
      return longint'(e) * longint'(LN2_Q32_V) + longint'(2 * sum);
    endfunction

    // ln(n/100) in Q24, floored at zero
    function longint unsigned ln_ratio(int unsigned n);
      longint d;
      d = ln_fixed(n) - ln_fixed(100);
      if (d <= 0) return 0;
      return longint'(d) >>> 8;
    endfunction

    function longint unsigned exp_neg(longint unsigned x);
      longint sum;
      longint unsigned term;
      sum = 64'sd1 <<< 32;
      term = 64'd1 << 32;
      if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
      for (int k = 1; k <= 20; k++) begin
        term = ((term * x) >> 32) / k;
        if (k & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      return sum < 0 ? 0 : longint'(sum);
    endfunction

    function bit [16:0] round_gain(longint num);
      longint unsigned q24, q16;
      if (num <= 0) return GAIN_ZERO;
      q24 = longint'(num) / DEN_Q24_V;
      q16 = (q24 + 128) >> 8;
      return q16 > 65536 ? GAIN_ONE : 17'(q16);
    endfunction

    function bit [16:0] log_gain(int unsigned n, longint a, longint b);
      return round_gain(a * longint'(ln_ratio(n)) - b * (64'sd1 <<< 24));
    endfunction

    function bit [16:0] pow_gain(int unsigned u, longint unsigned c, longint unsigned ex);
      longint unsigned x24, e24;
      x24 = (ex * ln_ratio(u)) / 64'd100000000;
      e24 = exp_neg(x24 << 8) >> 8;
      return round_gain(longint'(c * e24));
    endfunction

    function void update_gains();
      int unsigned k;
      k = kelvin;
      if (k < KELVIN_MIN) k = KELVIN_MIN;
      if (k > KELVIN_MAX) k = KELVIN_MAX;
      gains[CH_RED] = (k <= KELVIN_KNEE) ? GAIN_ONE
                      : pow_gain(k - 6000, 64'd32969872745, 64'd13320476);
      gains[CH_GREEN] = (k <= KELVIN_KNEE)
                        ? log_gain(k, 64'sd9947080259, 64'sd16111956817)
                        : pow_gain(k - 6000, 64'd28812216953, 64'd7551485);
      if (k >= KELVIN_KNEE) gains[CH_BLUE] = GAIN_ONE;
      else if (k <= KELVIN_BLUE0) gains[CH_BLUE] = GAIN_ZERO;
      else gains[CH_BLUE] = log_gain(k - 1000, 64'sd13851773122, 64'sd30504479273);
      gains[3] = GAIN_ONE;
    endfunction

    function void set_kelvin(bit [15:0] k);
      kelvin = k;
      update_gains();
    endfunction

    function void note_entry(bit [1:0] ch, bit [15:0] base);
      longint unsigned v;
      v = (64'(base) * 64'(gains[ch]) + 32768) >> 16;
      if (v > 65535) v = 65535;
      pending_scaled.push_back(16'(v));
    endfunction

    function void check_scaled(bit [15:0] got);
      bit [15:0] want;
      if (pending_scaled.size() == 0) begin
        report_mismatch($sformatf("unexpected beat scaled_value=%0d", got));
        return;
      end
      want = pending_scaled.pop_front();
      if (got !== want)
        report_mismatch($sformatf("kelvin %0d: scaled_value %0d, want %0d", kelvin, got, want));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] channel = '0;
  logic [15:0] base_value = '0;
  logic out_valid, out_ready = 1'b0;
  logic [15:0] scaled_value;

  ramp_scoreboard sb = new();
  bit quiet_mode = 0;      // no idling in the last part
  bit hold_sink = 0;       // long receiver hold-off
  int idle_cycles = 0;

  always #5 clk = ~clk;

  color_temperature_ramp_scaler_core DUT (.*);

  // Result side: random stalls, checks each accepted beat
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_scaled(scaled_value);
      if (hold_sink || (!quiet_mode && $urandom_range(0, 5) == 0)) out_ready <= 1'b0;
      else out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat or register access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Valid stays high from beat to beat; it drops only for a gap or a drain
  task automatic send_entry(bit [1:0] ch, bit [15:0] base);
    int gap;
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    base_value <= base;
    do @(posedge clk); while (!in_ready);
    sb.note_entry(ch, base);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_scaled.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_kelvin(bit [15:0] k);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(CFG_IDX_KELVIN) << 2;
    pwdata <= {16'd0, k};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_kelvin(k);
  endtask

  task automatic random_entries(int n);
    for (int i = 0; i < n; i++)
      send_entry(2'($urandom_range(0, 3)), $urandom_range(0, 1) ? 16'($urandom) :
                 ($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3))));
  endtask

  initial begin
    bit [15:0] kelvins [] = '{16'd1000, 16'd40000, 16'd0, 16'd65535, 16'd1900, 16'd1901,
                              16'd6600, 16'd6601, 16'd3200, 16'd9300};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset white point, field extremes, every channel
    for (int ch = 0; ch < 4; ch++) begin
      send_entry(2'(ch), 16'd0);
      send_entry(2'(ch), 16'hFFFF);
      send_entry(2'(ch), 16'h8000);
      send_entry(2'(ch), 16'h5555);
    end
    drain();

    // Receiver holds off long while entries keep coming
    hold_sink = 1;
    fork
      random_entries(20);
      begin repeat (60) @(posedge clk); hold_sink = 0; end
    join
    drain();

    // Several white points including extremes and curve knees
    foreach (kelvins[i]) begin
      write_kelvin(kelvins[i]);
      random_entries(90);
      drain();
    end
    for (int i = 0; i < 4; i++) begin
      write_kelvin(16'($urandom_range(0, 65535)));
      random_entries(60);
      drain();
    end
    write_kelvin(16'($urandom_range(1000, 40000)));
    quiet_mode = 1;
    random_entries(150);
    drain();

    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
